@@ rtl/tccw_pkg.sv @@
// Shared types, sizes and helper functions for the text console character writer.
// Used by every module of the block but tccw_ram; no dependencies of its own.
`default_nettype none

package tccw_pkg;

  // Screen geometry and tab size
  localparam int MAX_COLS  = 128;
  localparam int MAX_ROWS  = 64;
  localparam int TAB_WIDTH = 8;

  localparam int CHAR_W = 7;                         // cell content width
  localparam int COL_W  = $clog2(MAX_COLS);          // column index
  localparam int ROW_W  = $clog2(MAX_ROWS);          // row index
  localparam int NCOL_W = $clog2(MAX_COLS + 1);      // column count, or index one past
  localparam int NROW_W = $clog2(MAX_ROWS + 1);      // row count, or index one past
  localparam int TCNT_W = $clog2(TAB_WIDTH + 1);     // spaces written by a tab
  localparam int CFG_W  = 8;                         // widest register
  localparam int CIDX_W = 2;                         // register index

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_COLS  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_ROWS  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_PCOL  = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_PROW  = 2'd3;

  // Register reset values
  localparam logic [NCOL_W-1:0] COLS_RESET = NCOL_W'(80);
  localparam logic [NROW_W-1:0] ROWS_RESET = NROW_W'(24);

  // Byte codes
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PRINT_LAST = 8'h7E;

  localparam logic [CHAR_W-1:0] CELL_SPACE = CHAR_W'(CH_SPACE);

  // One full row of cells
  typedef logic [MAX_COLS-1:0][CHAR_W-1:0] row_t;

  typedef enum logic [2:0] {
    BC_CR,
    BC_TAB,
    BC_BS,
    BC_LF,
    BC_PRINT,
    BC_OTHER
  } byte_cls_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_PR_LOAD,
    S_PR_PUT,
    S_PR_STORE,
    S_TAB_RD,
    S_TAB_LOAD,
    S_TAB_PUT,
    S_TAB_WRAP,
    S_BS_LOAD1,
    S_BS_ZERO1,
    S_BS_BACK,
    S_BS_RD2,
    S_BS_LOAD2,
    S_BS_ZERO2,
    S_STORE,
    S_SETTLE,
    S_SC_LOAD,
    S_SC_STEP,
    S_SC_MOVE,
    S_DONE
  } ctl_state_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLR,
    DP_ITEM,
    DP_RD_CELL,
    DP_RD_CUR,
    DP_LOAD,
    DP_CR,
    DP_LF,
    DP_PUT_BYTE,
    DP_PUT_ZERO,
    DP_TAB_PUT,
    DP_STORE,
    DP_STORE_ADV,
    DP_STORE_WRAP,
    DP_STORE_BACK,
    DP_SC_START,
    DP_SC_RD,
    DP_SC_MOVE,
    DP_SC_LAST,
    DP_DONE
  } dp_op_t;

  typedef struct packed {
    logic      is_read;
    byte_cls_t cls;
    logic      at_prompt;
    logic      at_edge;
    logic      row_over;
    logic      tab_last;
    logic      tab_done;
    logic      sc_more;
    logic      clr_last;
    logic      out_free;
  } dp_status_t;

  function automatic byte_cls_t byte_class(input logic [7:0] b);
    byte_cls_t c;
    case (b) inside
      CH_CR:                  c = BC_CR;
      CH_TAB:                 c = BC_TAB;
      CH_BS:                  c = BC_BS;
      CH_LF, CH_VT, CH_FF:    c = BC_LF;
      [CH_SPACE:CH_PRINT_LAST]: c = BC_PRINT;
      default:                c = BC_OTHER;
    endcase
    return c;
  endfunction

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [NCOL_W-1:0] eff_cols(input logic [7:0] v);
    logic [NCOL_W-1:0] r;
    if (v == 8'd0) r = NCOL_W'(1);
    else if (int'(v) > MAX_COLS) r = NCOL_W'(MAX_COLS);
    else r = NCOL_W'(v);
    return r;
  endfunction

  function automatic logic [NROW_W-1:0] eff_rows(input logic [6:0] v);
    logic [NROW_W-1:0] r;
    if (v == 7'd0) r = NROW_W'(1);
    else if (int'(v) > MAX_ROWS) r = NROW_W'(MAX_ROWS);
    else r = NROW_W'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tccw_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [$clog2(DEPTH)-1:0]          waddr,
  input  wire logic [WIDTH-1:0]                  wdata,
  input  wire logic                              re,
  input  wire logic [$clog2(DEPTH)-1:0]          raddr,
  output      logic [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/tccw_ctrl.sv @@
// Sequencer for the console: steps each item through row loads, edits, stores and scrolls.
// Depends on tccw_pkg; drives tccw_dpath through a one-op-per-cycle command.
`default_nettype none

module tccw_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire tccw_pkg::dp_status_t   status,
  output      logic                   in_ready,
  output      tccw_pkg::dp_op_t       dp_op,
  output      tccw_pkg::ctl_state_t   state
);

  tccw_pkg::ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tccw_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_op      = tccw_pkg::DP_NOP;
    in_ready   = 1'b0;
    case (state)
      tccw_pkg::S_CLEAR: begin
        dp_op = tccw_pkg::DP_CLR;
        if (status.clr_last) state_next = tccw_pkg::S_IDLE;
      end
      tccw_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_op      = tccw_pkg::DP_ITEM;
          state_next = tccw_pkg::S_DECODE;
        end
      end
      tccw_pkg::S_DECODE: begin
        if (status.is_read) begin
          dp_op      = tccw_pkg::DP_RD_CELL;
          state_next = tccw_pkg::S_DONE;
        end else begin
          case (status.cls)
            tccw_pkg::BC_CR: begin
              dp_op      = tccw_pkg::DP_CR;
              state_next = tccw_pkg::S_DONE;
            end
            tccw_pkg::BC_LF: begin
              dp_op      = tccw_pkg::DP_LF;
              state_next = tccw_pkg::S_SETTLE;
            end
            tccw_pkg::BC_PRINT: begin
              dp_op      = tccw_pkg::DP_RD_CUR;
              state_next = tccw_pkg::S_PR_LOAD;
            end
            tccw_pkg::BC_TAB: begin
              dp_op      = tccw_pkg::DP_RD_CUR;
              state_next = tccw_pkg::S_TAB_LOAD;
            end
            tccw_pkg::BC_BS: begin
              if (status.at_prompt) begin
                state_next = tccw_pkg::S_DONE;
              end else begin
                dp_op      = tccw_pkg::DP_RD_CUR;
                state_next = tccw_pkg::S_BS_LOAD1;
              end
            end
            default: state_next = tccw_pkg::S_DONE;
          endcase
        end
      end
      tccw_pkg::S_PR_LOAD: begin
        dp_op      = tccw_pkg::DP_LOAD;
        state_next = tccw_pkg::S_PR_PUT;
      end
      tccw_pkg::S_PR_PUT: begin
        dp_op      = tccw_pkg::DP_PUT_BYTE;
        state_next = tccw_pkg::S_PR_STORE;
      end
      tccw_pkg::S_PR_STORE: begin
        dp_op      = tccw_pkg::DP_STORE_ADV;
        state_next = tccw_pkg::S_SETTLE;
      end
      tccw_pkg::S_TAB_RD: begin
        dp_op      = tccw_pkg::DP_RD_CUR;
        state_next = tccw_pkg::S_TAB_LOAD;
      end
      tccw_pkg::S_TAB_LOAD: begin
        dp_op      = tccw_pkg::DP_LOAD;
        state_next = tccw_pkg::S_TAB_PUT;
      end
      tccw_pkg::S_TAB_PUT: begin
        dp_op = tccw_pkg::DP_TAB_PUT;
        if (status.at_edge) state_next = tccw_pkg::S_TAB_WRAP;
        else if (status.tab_last) state_next = tccw_pkg::S_STORE;
      end
      tccw_pkg::S_TAB_WRAP: begin
        dp_op      = tccw_pkg::DP_STORE_WRAP;
        state_next = tccw_pkg::S_SETTLE;
      end
      tccw_pkg::S_BS_LOAD1: begin
        dp_op      = tccw_pkg::DP_LOAD;
        state_next = tccw_pkg::S_BS_ZERO1;
      end
      tccw_pkg::S_BS_ZERO1: begin
        dp_op      = tccw_pkg::DP_PUT_ZERO;
        state_next = tccw_pkg::S_BS_BACK;
      end
      tccw_pkg::S_BS_BACK: begin
        dp_op      = tccw_pkg::DP_STORE_BACK;
        state_next = tccw_pkg::S_BS_RD2;
      end
      tccw_pkg::S_BS_RD2: begin
        dp_op      = tccw_pkg::DP_RD_CUR;
        state_next = tccw_pkg::S_BS_LOAD2;
      end
      tccw_pkg::S_BS_LOAD2: begin
        dp_op      = tccw_pkg::DP_LOAD;
        state_next = tccw_pkg::S_BS_ZERO2;
      end
      tccw_pkg::S_BS_ZERO2: begin
        dp_op      = tccw_pkg::DP_PUT_ZERO;
        state_next = tccw_pkg::S_STORE;
      end
      tccw_pkg::S_STORE: begin
        dp_op      = tccw_pkg::DP_STORE;
        state_next = tccw_pkg::S_DONE;
      end
      tccw_pkg::S_SETTLE: begin
        // Scroll if the cursor ran off the bottom, else finish or resume a tab
        if (status.row_over) begin
          dp_op      = tccw_pkg::DP_SC_START;
          state_next = tccw_pkg::S_SC_LOAD;
        end else if (status.cls == tccw_pkg::BC_TAB && !status.is_read && !status.tab_done) begin
          state_next = tccw_pkg::S_TAB_RD;
        end else begin
          state_next = tccw_pkg::S_DONE;
        end
      end
      tccw_pkg::S_SC_LOAD: begin
        dp_op      = tccw_pkg::DP_LOAD;
        state_next = tccw_pkg::S_SC_STEP;
      end
      tccw_pkg::S_SC_STEP: begin
        if (status.sc_more) begin
          dp_op      = tccw_pkg::DP_SC_RD;
          state_next = tccw_pkg::S_SC_MOVE;
        end else begin
          dp_op      = tccw_pkg::DP_SC_LAST;
          state_next = tccw_pkg::S_SETTLE;
        end
      end
      tccw_pkg::S_SC_MOVE: begin
        dp_op      = tccw_pkg::DP_SC_MOVE;
        state_next = tccw_pkg::S_SC_STEP;
      end
      tccw_pkg::S_DONE: begin
        if (status.out_free) begin
          dp_op      = tccw_pkg::DP_DONE;
          state_next = tccw_pkg::S_IDLE;
        end
      end
      default: state_next = tccw_pkg::S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/tccw_dpath.sv @@
// Datapath for the console: registers, cursor, row buffer, result register, screen RAM.
// Depends on tccw_pkg and tccw_ram; driven by tccw_ctrl one op per cycle.
`default_nettype none

module tccw_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tccw_pkg::dp_op_t              dp_op,
  output      tccw_pkg::dp_status_t          status,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tccw_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [tccw_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          op,
  input  wire logic [7:0]                    byte_in,
  input  wire logic [tccw_pkg::ROW_W-1:0]    read_row,
  input  wire logic [tccw_pkg::COL_W-1:0]    read_col,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [tccw_pkg::CHAR_W-1:0]   cell_char,
  output      logic [tccw_pkg::COL_W-1:0]    cursor_col,
  output      logic [tccw_pkg::ROW_W-1:0]    cursor_row,
  output      logic                          scrolled
);

  // Configuration, kept in effective form
  logic [tccw_pkg::NCOL_W-1:0] cols;
  logic [tccw_pkg::NROW_W-1:0] rows;
  logic [tccw_pkg::COL_W-1:0]  pcol;
  logic [tccw_pkg::ROW_W-1:0]  prow;

  // Cursor; the row may sit one past the last row until settled
  logic [tccw_pkg::COL_W-1:0]  ccol;
  logic [tccw_pkg::NROW_W-1:0] crow;
  logic                        wrap;

  // Latched item
  logic                        item_op;
  logic [7:0]                  item_byte;
  logic [tccw_pkg::ROW_W-1:0]  item_rrow;
  logic [tccw_pkg::COL_W-1:0]  item_rcol;

  logic [tccw_pkg::ROW_W-1:0]  sidx;      // clear / scroll sweep row
  logic [tccw_pkg::TCNT_W-1:0] tcnt;
  logic                        scr;
  tccw_pkg::row_t              rowbuf;

  // RAM ports
  logic                        ram_we;
  logic [tccw_pkg::ROW_W-1:0]  ram_waddr;
  tccw_pkg::row_t              ram_wdata;
  logic                        ram_re;
  logic [tccw_pkg::ROW_W-1:0]  ram_raddr;
  tccw_pkg::row_t              rdata;

  // Scroll merge: columns in use take the row below (zeros for the bottom row), the rest keep their contents
  logic [tccw_pkg::MAX_COLS-1:0] col_mask;
  tccw_pkg::row_t                sc_src;
  tccw_pkg::row_t                merged;

  logic [tccw_pkg::NCOL_W-1:0] ncols;
  logic [tccw_pkg::NROW_W-1:0] nrows;
  logic [tccw_pkg::NCOL_W-1:0] ccol_inc;
  logic                        rd_ok;

  tccw_ram #(
    .WIDTH ($bits(tccw_pkg::row_t)),
    .DEPTH (tccw_pkg::MAX_ROWS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_comb begin
    for (int k = 0; k < tccw_pkg::MAX_COLS; k++) begin
      col_mask[k] = (tccw_pkg::NCOL_W'(k) < cols);
    end
    sc_src = (dp_op == tccw_pkg::DP_SC_LAST) ? '0 : rdata;
    for (int k = 0; k < tccw_pkg::MAX_COLS; k++) begin
      merged[k] = col_mask[k] ? sc_src[k] : rowbuf[k];
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = crow[tccw_pkg::ROW_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = crow[tccw_pkg::ROW_W-1:0];
    ram_wdata = rowbuf;
    case (dp_op)
      tccw_pkg::DP_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = sidx;
        ram_wdata = '0;
      end
      tccw_pkg::DP_RD_CELL: begin
        ram_re    = 1'b1;
        ram_raddr = item_rrow;
      end
      tccw_pkg::DP_RD_CUR: ram_re = 1'b1;
      tccw_pkg::DP_SC_START: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      tccw_pkg::DP_SC_RD: begin
        ram_re    = 1'b1;
        ram_raddr = sidx + tccw_pkg::ROW_W'(1);
      end
      tccw_pkg::DP_STORE, tccw_pkg::DP_STORE_ADV, tccw_pkg::DP_STORE_WRAP,
      tccw_pkg::DP_STORE_BACK: ram_we = 1'b1;
      tccw_pkg::DP_SC_MOVE, tccw_pkg::DP_SC_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = sidx;
        ram_wdata = merged;
      end
      default: ;
    endcase
  end

  always_comb begin
    ncols = (cfg_index == tccw_pkg::CFG_COLS) ? tccw_pkg::eff_cols(cfg_data[7:0]) : cols;
    nrows = (cfg_index == tccw_pkg::CFG_ROWS) ? tccw_pkg::eff_rows(cfg_data[6:0]) : rows;
    ccol_inc = tccw_pkg::NCOL_W'(ccol) + tccw_pkg::NCOL_W'(1);
    rd_ok = (tccw_pkg::NROW_W'(item_rrow) < rows) && (tccw_pkg::NCOL_W'(item_rcol) < cols);

    status.is_read   = item_op;
    status.cls       = tccw_pkg::byte_class(item_byte);
    status.at_prompt = (ccol == pcol) && (crow == tccw_pkg::NROW_W'(prow));
    status.at_edge   = ccol_inc >= cols;
    status.row_over  = crow >= rows;
    status.tab_last  = tcnt == tccw_pkg::TCNT_W'(tccw_pkg::TAB_WIDTH - 1);
    status.tab_done  = tcnt == tccw_pkg::TCNT_W'(tccw_pkg::TAB_WIDTH);
    status.sc_more   = (tccw_pkg::NROW_W'(sidx) + tccw_pkg::NROW_W'(1)) < rows;
    status.clr_last  = sidx == tccw_pkg::ROW_W'(tccw_pkg::MAX_ROWS - 1);
    status.out_free  = !out_valid || out_ready;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cols      <= tccw_pkg::COLS_RESET;
      rows      <= tccw_pkg::ROWS_RESET;
      pcol      <= '0;
      prow      <= '0;
      ccol      <= '0;
      crow      <= '0;
      wrap      <= 1'b0;
      sidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          tccw_pkg::CFG_COLS: cols <= ncols;
          tccw_pkg::CFG_ROWS: rows <= nrows;
          tccw_pkg::CFG_PCOL: pcol <= cfg_data[tccw_pkg::COL_W-1:0];
          tccw_pkg::CFG_PROW: prow <= cfg_data[tccw_pkg::ROW_W-1:0];
          default: ;
        endcase
        // Pull the cursor back inside the new area
        if (tccw_pkg::NCOL_W'(ccol) >= ncols) begin
          ccol <= tccw_pkg::COL_W'(ncols - tccw_pkg::NCOL_W'(1));
        end
        if (crow >= nrows) begin
          crow <= nrows - tccw_pkg::NROW_W'(1);
        end
      end

      case (dp_op)
        tccw_pkg::DP_CLR: sidx <= sidx + tccw_pkg::ROW_W'(1);
        tccw_pkg::DP_CR:  ccol <= '0;
        tccw_pkg::DP_LF: begin
          if (wrap) wrap <= 1'b0;
          else crow <= crow + tccw_pkg::NROW_W'(1);
        end
        tccw_pkg::DP_TAB_PUT: begin
          if (!status.at_edge) ccol <= ccol + tccw_pkg::COL_W'(1);
        end
        tccw_pkg::DP_STORE_ADV: begin
          if (status.at_edge) begin
            ccol <= '0;
            crow <= crow + tccw_pkg::NROW_W'(1);
            wrap <= 1'b1;
          end else begin
            ccol <= ccol + tccw_pkg::COL_W'(1);
            wrap <= 1'b0;
          end
        end
        tccw_pkg::DP_STORE_WRAP: begin
          ccol <= '0;
          crow <= crow + tccw_pkg::NROW_W'(1);
        end
        tccw_pkg::DP_STORE_BACK: begin
          if (ccol == '0) begin
            ccol <= tccw_pkg::COL_W'(cols - tccw_pkg::NCOL_W'(1));
            if (crow != '0) crow <= crow - tccw_pkg::NROW_W'(1);
          end else begin
            ccol <= ccol - tccw_pkg::COL_W'(1);
          end
        end
        tccw_pkg::DP_SC_START: sidx <= '0;
        tccw_pkg::DP_SC_MOVE:  sidx <= sidx + tccw_pkg::ROW_W'(1);
        tccw_pkg::DP_SC_LAST:  crow <= rows - tccw_pkg::NROW_W'(1);
        default: ;
      endcase

      if (dp_op == tccw_pkg::DP_DONE) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    case (dp_op)
      tccw_pkg::DP_ITEM: begin
        item_op   <= op;
        item_byte <= byte_in;
        item_rrow <= read_row;
        item_rcol <= read_col;
        tcnt      <= '0;
        scr       <= 1'b0;
      end
      tccw_pkg::DP_LOAD:     rowbuf <= rdata;
      tccw_pkg::DP_PUT_BYTE: rowbuf[ccol] <= item_byte[tccw_pkg::CHAR_W-1:0];
      tccw_pkg::DP_PUT_ZERO: rowbuf[ccol] <= '0;
      tccw_pkg::DP_TAB_PUT: begin
        rowbuf[ccol] <= tccw_pkg::CELL_SPACE;
        tcnt         <= tcnt + tccw_pkg::TCNT_W'(1);
      end
      tccw_pkg::DP_SC_MOVE:  rowbuf <= rdata;
      tccw_pkg::DP_SC_LAST:  scr <= 1'b1;
      tccw_pkg::DP_DONE: begin
        cell_char  <= (item_op && rd_ok) ? rdata[item_rcol] : '0;
        cursor_col <= ccol;
        cursor_row <= crow[tccw_pkg::ROW_W-1:0];
        scrolled   <= scr;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/text_console_char_writer_core.sv @@
// Text console character writer: 1 item in flight. A scroll, when needed, adds a sweep
// over the rows in use. The next item can be taken the cycle after its result is placed
// in the output register. The screen RAM is row-wide: a whole row is read or written at once.
// After reset the RAM is swept clear, one row per cycle, over all 64 rows; no item is taken.
`default_nettype none

module text_console_char_writer_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration write port
  input  wire logic                          cfg_wr_en,
  input  wire logic [tccw_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [tccw_pkg::CFG_W-1:0]    cfg_data,
  // Input item channel
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          op,
  input  wire logic [7:0]                    byte_in,
  input  wire logic [tccw_pkg::ROW_W-1:0]    read_row,
  input  wire logic [tccw_pkg::COL_W-1:0]    read_col,
  // Result item channel
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [tccw_pkg::CHAR_W-1:0]   cell_char,
  output      logic [tccw_pkg::COL_W-1:0]    cursor_col,
  output      logic [tccw_pkg::ROW_W-1:0]    cursor_row,
  output      logic                          scrolled
);

  tccw_pkg::dp_op_t     dp_op;
  tccw_pkg::dp_status_t status;
  tccw_pkg::ctl_state_t state;

  // The controller walks each item through its steps: a feed that touches
  // cells loads the cursor row into a row buffer, edits cells there and
  // writes the row back. A move past the bottom row starts a scroll sweep
  // that copies each row from the one below (columns in use only) and
  // clears the bottom row.
  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .dp_op    (dp_op),
    .state    (state)
  );

  // The datapath holds registers, cursor, wrap flag, row buffer, the screen
  // RAM and the result register. The result register lets the next item be
  // taken while a finished result still waits on out_ready.
  tccw_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .dp_op      (dp_op),
    .status     (status),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op         (op),
    .byte_in    (byte_in),
    .read_row   (read_row),
    .read_col   (read_col),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_char  (cell_char),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled)
  );

  // Cursor must be back on screen once an item is settled
  a_row_settled: assert property (@(posedge clk) disable iff (rst)
    (state == tccw_pkg::S_IDLE || state == tccw_pkg::S_DONE) |-> !status.row_over)
    else $error("cursor row past last row outside a scroll");

  // One item at a time: taking an item closes the input until it finishes
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  // A new result appears only from the finish step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == tccw_pkg::S_DONE))
    else $error("result raised outside the finish step");

endmodule

`default_nettype wire

@@ tb/console_cell_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the text console character writer: keeps its own copy of the screen,
// cursor, line-feed absorb flag and registers, predicts every result item and compares it.
// Depends on tccw_pkg for sizes, register indexes and byte codes.

module console_cell_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tccw_pkg::CIDX_W-1:0] cfg_index,
  input  logic [tccw_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        op,
  input  logic [7:0]                  byte_in,
  input  logic [tccw_pkg::ROW_W-1:0]  read_row,
  input  logic [tccw_pkg::COL_W-1:0]  read_col,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [tccw_pkg::CHAR_W-1:0] cell_char,
  input  logic [tccw_pkg::COL_W-1:0]  cursor_col,
  input  logic [tccw_pkg::ROW_W-1:0]  cursor_row,
  input  logic                        scrolled,
  output int                          mismatches,
  output int                          results_owed
);
  import tccw_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              scr;
  } cursor_report_t;

  logic [CHAR_W-1:0] cells [MAX_ROWS][MAX_COLS];
  int                cur_col;
  int                cur_row;     // may sit one past the bottom until the scroll check
  bit                lf_absorb;   // set by a printable byte that wrapped the line
  logic [7:0]        reg_cols;
  logic [6:0]        reg_rows;
  logic [6:0]        guard_col;
  logic [5:0]        guard_row;
  cursor_report_t    owed_reports [$];

  initial begin
    mismatches   = 0;
    results_owed = 0;
  end

  function automatic int active_cols();
    if (reg_cols == 8'd0) return 1;
    if (reg_cols > MAX_COLS) return MAX_COLS;
    return int'(reg_cols);
  endfunction

  function automatic int active_rows();
    if (reg_rows == 7'd0) return 1;
    if (reg_rows > MAX_ROWS) return MAX_ROWS;
    return int'(reg_rows);
  endfunction

  function automatic void pull_cursor_inside();
    if (cur_col >= active_cols()) cur_col = active_cols() - 1;
    if (cur_row >= active_rows()) cur_row = active_rows() - 1;
  endfunction

  // Shift the area in use up one row once the cursor has dropped off the bottom.
  function automatic bit scroll_past_bottom();
    int ncol;
    int nrow;
    ncol = active_cols();
    nrow = active_rows();
    if (cur_row < nrow) return 1'b0;
    for (int r = 0; r + 1 < nrow; r++)
      for (int c = 0; c < ncol; c++) cells[r][c] = cells[r + 1][c];
    for (int c = 0; c < ncol; c++) cells[nrow - 1][c] = '0;
    cur_row = nrow - 1;
    return 1'b1;
  endfunction

  function automatic void reset_console();
    for (int r = 0; r < MAX_ROWS; r++)
      for (int c = 0; c < MAX_COLS; c++) cells[r][c] = '0;
    cur_col   = 0;
    cur_row   = 0;
    lf_absorb = 1'b0;
    reg_cols  = 8'(COLS_RESET);
    reg_rows  = 7'(ROWS_RESET);
    guard_col = '0;
    guard_row = '0;
  endfunction

  function automatic void write_register(input logic [CIDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
    case (idx)
      CFG_COLS: reg_cols  = data;
      CFG_ROWS: reg_rows  = data[6:0];
      CFG_PCOL: guard_col = data[6:0];
      CFG_PROW: guard_row = data[5:0];
      default: ;
    endcase
    pull_cursor_inside();
  endfunction

  // Apply one input item to the mirrored console and return the report it yields.
  function automatic cursor_report_t advance_console(input logic is_read,
                                                     input logic [7:0] b,
                                                     input logic [ROW_W-1:0] rr,
                                                     input logic [COL_W-1:0] rc);
    cursor_report_t rep;
    int ncol;
    ncol = active_cols();
    rep  = '0;
    if (is_read) begin
      if (rr < active_rows() && rc < ncol) rep.glyph = cells[rr][rc];
    end else begin
      pull_cursor_inside();
      if (b == CH_CR) begin
        cur_col = 0;
      end else if (b == CH_TAB) begin
        for (int k = 0; k < TAB_WIDTH; k++) begin
          cells[cur_row][cur_col] = CELL_SPACE;
          cur_col++;
          if (cur_col >= ncol) begin
            cur_col = 0;
            cur_row++;
            if (scroll_past_bottom()) rep.scr = 1'b1;
          end
        end
      end else if (b == CH_BS) begin
        if (!(cur_col == guard_col && cur_row == guard_row)) begin
          cells[cur_row][cur_col] = '0;
          if (cur_col == 0) begin
            cur_col = ncol - 1;
            if (cur_row != 0) cur_row--;
          end else begin
            cur_col--;
          end
          cells[cur_row][cur_col] = '0;
        end
      end else if (b == CH_LF || b == CH_VT || b == CH_FF) begin
        if (lf_absorb) lf_absorb = 1'b0;
        else cur_row++;
      end else if (b >= CH_SPACE && b <= CH_PRINT_LAST) begin
        cells[cur_row][cur_col] = b[CHAR_W-1:0];
        cur_col++;
        if (cur_col >= ncol) begin
          cur_col   = 0;
          cur_row++;
          lf_absorb = 1'b1;
        end else begin
          lf_absorb = 1'b0;
        end
      end
      if (scroll_past_bottom()) rep.scr = 1'b1;
    end
    rep.col = COL_W'(cur_col);
    rep.row = ROW_W'(cur_row);
    return rep;
  endfunction

  function automatic void flag_bad(input string what, input cursor_report_t want,
                                   input cursor_report_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"[%0t] %s: expected cell %0d col %0d row %0d scrolled %0d,",
                " got cell %0d col %0d row %0d scrolled %0d"},
               $realtime, what, want.glyph, want.col, want.row, want.scr,
               got.glyph, got.col, got.row, got.scr);
  endfunction

  always @(posedge clk) begin : watch
    cursor_report_t got;
    cursor_report_t want;
    if (rst) begin
      reset_console();
      owed_reports.delete();
      results_owed = 0;
    end else begin
      if (cfg_wr_en) write_register(cfg_index, cfg_data);
      // A result can leave in the same cycle as a new item enters, so retire first.
      if (out_valid && out_ready) begin
        got = '{glyph: cell_char, col: cursor_col, row: cursor_row, scr: scrolled};
        if (owed_reports.size() == 0) begin
          flag_bad("unexpected result", '0, got);
        end else begin
          want = owed_reports.pop_front();
          if (got.glyph !== want.glyph || got.col !== want.col ||
              got.row !== want.row || got.scr !== want.scr)
            flag_bad("result mismatch", want, got);
        end
      end
      if (in_valid && in_ready)
        owed_reports.push_back(advance_console(op, byte_in, read_row, read_col));
      results_owed = owed_reports.size();
    end
  end

endmodule

@@ tb/text_console_char_writer_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the text console character writer testbench: clock, reset, register writes,
// byte and cell-read stimulus with random idling on both channels, and the verdict.
// Depends on tccw_pkg, text_console_char_writer_core and console_cell_checker.

module text_console_char_writer_core_tb;
  import tccw_pkg::*;

  localparam int   CYCLE_LIMIT   = 10_000_000;
  localparam int   SETTLE_CYCLES = 16;   // covers the slowest tail after the last result
  localparam int   HOLD_CYCLES   = 400;  // long receiver hold-off to back the block up
  localparam logic OP_FEED       = 1'b0;
  localparam logic OP_READ       = 1'b1;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = CFG_COLS;
  logic [CFG_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               op        = OP_FEED;
  logic [7:0]         byte_in   = '0;
  logic [ROW_W-1:0]   read_row  = '0;
  logic [COL_W-1:0]   read_col  = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [CHAR_W-1:0]  cell_char;
  logic [COL_W-1:0]   cursor_col;
  logic [ROW_W-1:0]   cursor_row;
  logic               scrolled;

  int mismatches;
  int results_owed;
  int cycle_count = 0;

  // Idling controls for the sender and the receiver process
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  int rx_hold_len = 0;

  // Area in use as the last register writes left it; steers reads toward live cells
  int act_cols = 80;
  int act_rows = 24;

  always #4 clk = ~clk;

  text_console_char_writer_core dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .byte_in(byte_in), .read_row(read_row), .read_col(read_col),
    .out_valid(out_valid), .out_ready(out_ready),
    .cell_char(cell_char), .cursor_col(cursor_col), .cursor_row(cursor_row),
    .scrolled(scrolled)
  );

  console_cell_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .byte_in(byte_in), .read_row(read_row), .read_col(read_col),
    .out_valid(out_valid), .out_ready(out_ready),
    .cell_char(cell_char), .cursor_col(cursor_col), .cursor_row(cursor_row),
    .scrolled(scrolled),
    .mismatches(mismatches), .results_owed(results_owed)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: take results, stall in random bursts, and honor a requested long hold.
  // Every branch ends with out_ready driven high.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
        out_ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one item and hold it until the block takes it. Leave valid high on return,
  // so back-to-back items never drop valid in between.
  task automatic feed(input logic o, input logic [7:0] b,
                      input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
    in_valid <= 1'b1;
    op       <= o;
    byte_in  <= b;
    read_row <= rr;
    read_col <= rc;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid for a random burst now and then.
  task automatic sender_gap();
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Stop offering, wait until every result item is back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_owed == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges; call only while the block is idle.
  task automatic configure(input logic [7:0] c, input logic [7:0] r,
                           input logic [7:0] pc, input logic [7:0] pr);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_COLS;
    cfg_data  <= c;
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_data  <= r;
    @(posedge clk);
    cfg_index <= CFG_PCOL;
    cfg_data  <= pc;
    @(posedge clk);
    cfg_index <= CFG_PROW;
    cfg_data  <= pr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    act_cols = (c == 8'd0) ? 1 : (c > MAX_COLS) ? MAX_COLS : int'(c);
    act_rows = (r[6:0] == 7'd0) ? 1 : (r[6:0] > MAX_ROWS) ? MAX_ROWS : int'(r[6:0]);
  endtask

  // One random item: mostly printable text with control bytes mixed in, some cell
  // reads (most inside the area in use), and a share of bytes the block ignores.
  task automatic random_item();
    int                pick;
    logic [7:0]        b;
    logic [ROW_W-1:0]  rr;
    logic [COL_W-1:0]  rc;
    pick = $urandom_range(0, 99);
    b    = $urandom_range(0, 255);
    rr   = $urandom_range(0, MAX_ROWS - 1);
    rc   = $urandom_range(0, MAX_COLS - 1);
    if (pick < 14) begin
      if (pick < 9) begin
        rr = $urandom_range(0, act_rows - 1);
        rc = $urandom_range(0, act_cols - 1);
      end
      feed(OP_READ, b, rr, rc);
    end else begin
      if (pick < 62)      b = $urandom_range(CH_SPACE, CH_PRINT_LAST);
      else if (pick < 65) b = CH_LF;
      else if (pick < 67) b = CH_VT;
      else if (pick < 70) b = CH_FF;
      else if (pick < 75) b = CH_CR;
      else if (pick < 81) b = CH_TAB;
      else if (pick < 89) b = CH_BS;
      else begin
        // ignored codes: low controls, the rest of the C0 range, DEL and the high half
        case ($urandom_range(0, 2))
          0:       b = $urandom_range(0, CH_BS - 1);
          1:       b = $urandom_range(CH_CR + 1, CH_SPACE - 1);
          default: b = $urandom_range(CH_PRINT_LAST + 1, 255);
        endcase
      end
      feed(OP_FEED, b, rr, rc);
    end
  endtask

  // One setting of the registers followed by a stretch of random items.
  // hold_at picks the item at which the receiver starts its long hold (-1: none).
  task automatic run_phase(input logic [7:0] c, input logic [7:0] r,
                           input logic [7:0] pc, input logic [7:0] pr,
                           input int count, input bit idle, input int hold_at);
    configure(c, r, pc, pr);
    tx_idle_on = idle;
    rx_idle_on = idle;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) rx_hold_len = HOLD_CYCLES;
      sender_gap();
      random_item();
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset geometry (80 x 24, prompt at the origin).
    // The block sweeps its store after reset; feed simply waits for ready.
    feed(OP_FEED, CH_BS, '0, '0);            // backspace on the prompt: no effect
    feed(OP_READ, 8'h00, 6'd0, 7'd0);        // freshly cleared cell
    feed(OP_FEED, 8'h41, '1, '1);            // 'A'
    feed(OP_FEED, CH_SPACE, '0, '0);         // lowest printable
    feed(OP_FEED, CH_PRINT_LAST, '0, '0);    // highest printable
    feed(OP_FEED, 8'h7F, '0, '0);            // DEL is ignored
    feed(OP_FEED, 8'hFF, '0, '0);            // top of the byte range, ignored
    feed(OP_FEED, 8'h00, '0, '0);            // NUL, ignored
    feed(OP_FEED, CH_TAB, '0, '0);
    feed(OP_FEED, CH_CR, '0, '0);
    feed(OP_FEED, CH_LF, '0, '0);
    feed(OP_FEED, CH_VT, '0, '0);
    feed(OP_FEED, CH_FF, '0, '0);
    feed(OP_FEED, CH_BS, '0, '0);            // from column 0: back to the row above
    feed(OP_READ, 8'hFF, 6'd0, 7'd0);
    feed(OP_READ, 8'h00, 6'd63, 7'd127);     // outside the area in use reads empty
    drain();

    // Tiny 4 x 2 screen: cursor is pulled inside, wraps, absorbed line feed,
    // tab that wraps twice and scrolls, backspace across a row boundary.
    configure(8'd4, 8'd2, 8'd1, 8'd1);
    feed(OP_FEED, 8'h61, '0, '0);
    feed(OP_FEED, 8'h62, '0, '0);
    feed(OP_FEED, 8'h63, '0, '0);
    feed(OP_FEED, 8'h64, '0, '0);
    feed(OP_FEED, 8'h65, '0, '0);            // wraps at the right edge, scrolls
    feed(OP_FEED, CH_LF, '0, '0);            // absorbed by the pending wrap
    feed(OP_FEED, CH_TAB, '0, '0);
    feed(OP_FEED, CH_BS, '0, '0);
    feed(OP_FEED, CH_LF, '0, '0);
    feed(OP_READ, 8'h00, 6'd1, 7'd3);
    drain();

    // Random phases over a spread of geometries, extremes included.
    run_phase(8'd0,   8'd0,   8'd0,   8'd0,   120, 1'b1, -1);  // zero acts as one
    run_phase(8'd255, 8'd127, 8'd127, 8'd63,  150, 1'b1, -1);  // above max acts as max
    run_phase(8'd8,   8'd4,   8'd5,   8'd2,   300, 1'b1, 40);  // long receiver hold
    run_phase(8'd1,   8'd64,  8'd0,   8'd5,   150, 1'b1, -1);
    run_phase(8'd128, 8'd1,   8'd3,   8'd0,   150, 1'b1, -1);
    run_phase($urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 255), 350, 1'b1, -1);
    run_phase(8'd13,  8'd5,   8'd12,  8'd4,   250, 1'b1, -1);
    run_phase(8'd20,  8'd3,   8'd2,   8'd1,   300, 1'b0, -1);  // no idling at the end

    if (mismatches == 0 && results_owed == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/tccw_pkg.sv
rtl/tccw_ram.sv
rtl/tccw_ctrl.sv
rtl/tccw_dpath.sv
rtl/text_console_char_writer_core.sv
tb/console_cell_checker.sv
tb/text_console_char_writer_core_tb.sv
